@@ rtl/tfwm_pkg.sv @@
// Shared types and character constants for the topic filter wildcard matcher.
package tfwm_pkg;

	// Item kinds on the input channel.
	localparam logic CMD_FILTER = 1'b0;
	localparam logic CMD_TOPIC  = 1'b1;

	// Characters with a special meaning in a topic filter.
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	// Matching state while a topic name streams in.
	typedef enum logic [2:0] {
		MODE_COMPARE,
		MODE_SKIP_LEVEL,
		MODE_LAST_LEVEL,
		MODE_TAIL,
		MODE_FAIL,
		MODE_INVALID
	} mode_t;

	// Update of the two-byte filter window that sits in front of the compare.
	typedef enum logic [1:0] {
		WIN_HOLD,
		WIN_STEP1,
		WIN_STEP2,
		WIN_RELOAD
	} win_op_t;

endpackage

@@ rtl/topic_filter_wildcard_match.sv @@
// The last topic byte is registered in the input stage, and its result in the result register.
// Throughput: one filter or topic byte per cycle unless result_ready stalls; the store has
// two read ports refilling a two-byte window register: each byte sees store[p] and store[p+1].
// Reset clears the control state: empty filter (no topic matches), matching at level start.
// The filter store itself is not cleared; only bytes of the current filter are ever used.
module topic_filter_wildcard_match #(
	parameter int MAX_TOPIC_LEN = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  logic       cmd,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       result_valid,
	input  logic       result_ready,
	output logic       is_match,
	output logic       invalid_filter
);

	localparam int AW = $clog2(MAX_TOPIC_LEN);
	localparam int LW = $clog2(MAX_TOPIC_LEN + 1);
	localparam logic [LW-1:0] MAX_LEN = LW'(MAX_TOPIC_LEN);

	// Input stage.
	logic       valid_s1;
	logic       cmd_s1;
	logic [7:0] data_s1;
	logic       last_s1;

	// Filter store and the window onto it.
	logic [7:0] store_q [MAX_TOPIC_LEN];
	logic [7:0] win0_q;
	logic [7:0] win1_q;

	// Control state.
	tfwm_pkg::mode_t mode_q, mode_d, step_mode;
	logic [LW-1:0]   pos_q, pos_d, step_pos;
	logic [LW-1:0]   len_q, len_d, base_len;
	logic            ovf_q, ovf_d;
	logic            sealed_q, sealed_d;
	tfwm_pkg::win_op_t win_op, step_win;

	// Result register.
	logic res_valid_q;
	logic is_match_q;
	logic invalid_q;

	// Handshake and datapath helpers.
	logic          gives_result;
	logic          out_free;
	logic          fire_s1;
	logic          res_fire;
	logic          has_next;
	logic          f_wild;
	logic          f_hash;
	logic          mem_we;
	logic [AW-1:0] waddr;
	logic [AW-1:0] addr_a;
	logic [AW-1:0] addr_b;
	logic [LW-1:0] pos_p2;
	logic [LW-1:0] pos_p3;
	logic          res_bad;
	logic          res_ok;

	// The input stage moves on unless it holds a result that cannot be stored yet.
	assign gives_result = (cmd_s1 == tfwm_pkg::CMD_TOPIC) && last_s1;
	assign out_free     = !res_valid_q || result_ready;
	assign fire_s1      = valid_s1 && (!gives_result || out_free);
	assign res_fire     = fire_s1 && gives_result;
	assign item_ready   = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			cmd_s1  <= cmd;
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// One matching step for a topic byte against the window.
	assign has_next = ((LW+1)'(pos_q) + (LW+1)'(1)) < (LW+1)'(len_q);
	assign f_wild   = (win0_q == tfwm_pkg::CH_PLUS) || (win0_q == tfwm_pkg::CH_HASH);
	assign f_hash   = (win0_q == tfwm_pkg::CH_HASH);
	assign pos_p2   = pos_q + LW'(2);
	assign pos_p3   = pos_q + LW'(3);

	always_comb begin
		step_mode = mode_q;
		step_pos  = pos_q;
		step_win  = tfwm_pkg::WIN_HOLD;
		unique case (mode_q)
			tfwm_pkg::MODE_COMPARE: begin
				if (pos_q >= len_q) begin
					step_mode = tfwm_pkg::MODE_FAIL;
				end else if (f_wild) begin
					if (has_next && (win1_q != tfwm_pkg::CH_SLASH)) begin
						step_mode = tfwm_pkg::MODE_INVALID;
					end else if (data_s1 == tfwm_pkg::CH_SLASH) begin
						step_mode = f_hash ? tfwm_pkg::MODE_INVALID : tfwm_pkg::MODE_FAIL;
					end else if (!has_next) begin
						step_mode = f_hash ? tfwm_pkg::MODE_TAIL : tfwm_pkg::MODE_LAST_LEVEL;
					end else begin
						step_pos  = pos_p2;
						step_mode = tfwm_pkg::MODE_SKIP_LEVEL;
						step_win  = tfwm_pkg::WIN_STEP2;
					end
				end else if (win0_q == data_s1) begin
					step_pos = pos_q + LW'(1);
					step_win = tfwm_pkg::WIN_STEP1;
				end else begin
					step_mode = tfwm_pkg::MODE_FAIL;
				end
			end
			tfwm_pkg::MODE_SKIP_LEVEL: begin
				if (data_s1 == tfwm_pkg::CH_SLASH) begin
					step_mode = tfwm_pkg::MODE_COMPARE;
				end
			end
			tfwm_pkg::MODE_LAST_LEVEL: begin
				if (data_s1 == tfwm_pkg::CH_SLASH) begin
					step_mode = tfwm_pkg::MODE_FAIL;
				end
			end
			default: begin
				step_mode = mode_q;
			end
		endcase
	end

	// Outcome of a finished topic name.
	assign res_bad = ovf_q || (step_mode == tfwm_pkg::MODE_INVALID);
	assign res_ok  = !res_bad &&
		(((step_mode == tfwm_pkg::MODE_COMPARE) && (step_pos == len_q)) ||
		 (step_mode == tfwm_pkg::MODE_LAST_LEVEL) || (step_mode == tfwm_pkg::MODE_TAIL));

	// Next state for filter loading and topic matching.
	assign base_len = sealed_q ? '0 : len_q;
	assign waddr    = base_len[AW-1:0];

	always_comb begin
		mode_d   = mode_q;
		pos_d    = pos_q;
		len_d    = len_q;
		ovf_d    = ovf_q;
		sealed_d = sealed_q;
		win_op   = tfwm_pkg::WIN_HOLD;
		mem_we   = 1'b0;
		if (fire_s1) begin
			if (cmd_s1 == tfwm_pkg::CMD_FILTER) begin
				// A filter byte after a complete filter starts a new one.
				len_d = base_len;
				ovf_d = ovf_q && !sealed_q;
				if (base_len < MAX_LEN) begin
					mem_we = 1'b1;
					len_d  = base_len + LW'(1);
				end else begin
					ovf_d = 1'b1;
				end
				sealed_d = last_s1;
				pos_d    = '0;
				mode_d   = tfwm_pkg::MODE_COMPARE;
				win_op   = tfwm_pkg::WIN_RELOAD;
			end else begin
				sealed_d = 1'b1;
				mode_d   = step_mode;
				pos_d    = step_pos;
				win_op   = step_win;
				if (last_s1) begin
					pos_d  = '0;
					mode_d = tfwm_pkg::MODE_COMPARE;
					win_op = tfwm_pkg::WIN_RELOAD;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= tfwm_pkg::MODE_COMPARE;
			pos_q    <= '0;
			len_q    <= '0;
			ovf_q    <= 1'b0;
			sealed_q <= 1'b1;
		end else begin
			mode_q   <= mode_d;
			pos_q    <= pos_d;
			len_q    <= len_d;
			ovf_q    <= ovf_d;
			sealed_q <= sealed_d;
		end
	end

	// Filter store: one write port, two read ports feeding the window.
	assign addr_a = (win_op == tfwm_pkg::WIN_RELOAD) ? AW'(0) : pos_p2[AW-1:0];
	assign addr_b = (win_op == tfwm_pkg::WIN_RELOAD) ? AW'(1) : pos_p3[AW-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_q[waddr] <= data_s1;
		end
	end

	// Reads see a byte written in the same cycle.
	always_ff @(posedge clk) begin
		case (win_op)
			tfwm_pkg::WIN_STEP1: begin
				win0_q <= win1_q;
				win1_q <= (mem_we && (waddr == addr_a)) ? data_s1 : store_q[addr_a];
			end
			tfwm_pkg::WIN_STEP2, tfwm_pkg::WIN_RELOAD: begin
				win0_q <= (mem_we && (waddr == addr_a)) ? data_s1 : store_q[addr_a];
				win1_q <= (mem_we && (waddr == addr_b)) ? data_s1 : store_q[addr_b];
			end
			default: begin
				win0_q <= win0_q;
				win1_q <= win1_q;
			end
		endcase
	end

	// Result register; a new result may load while the old one is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_fire) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_fire) begin
			is_match_q <= res_ok;
			invalid_q  <= res_bad;
		end
	end

	assign result_valid   = res_valid_q;
	assign is_match       = is_match_q;
	assign invalid_filter = invalid_q;

`ifndef SYNTH
	// A malformed filter never reports a match.
	a_match_not_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(is_match && invalid_filter))
		else $error("match and invalid filter reported together");

	// Matching never runs past the stored filter.
	a_pos_in_filter: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= len_q)
		else $error("filter position beyond filter length");

	// An overflow only happens with a full store.
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (len_q == MAX_LEN))
		else $error("overflow flagged with store not full");

	// Each finished topic name restarts matching at the filter start.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		res_fire |=> (mode_q == tfwm_pkg::MODE_COMPARE) && (pos_q == '0))
		else $error("matching not restarted after a result");

	// A result is never dropped while it waits for the consumer.
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |=> result_valid)
		else $error("pending result lost");
`endif

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the topic filter wildcard matcher.
`timescale 1ns / 1ps

module tb_top;

	localparam int FILT_DEPTH = 16;
	localparam int MAX_WAIT = 14;

	typedef logic [7:0] byte_t;

	typedef struct packed {
		logic is_match;
		logic invalid_filter;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	logic cmd = tfwm_pkg::CMD_FILTER;
	logic [7:0] data_byte = 8'h00;
	logic last_byte = 1'b0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic is_match;
	logic invalid_filter;

	// Mirror of the matcher state, advanced on every accepted input transfer.
	byte_t flt_bytes [FILT_DEPTH];
	int flt_len = 0;
	int flt_pos = 0;
	tfwm_pkg::mode_t flt_mode = tfwm_pkg::MODE_COMPARE;
	logic flt_overflow = 1'b0;
	logic flt_sealed = 1'b1;

	verdict_t expected_verdicts[$];
	int fail_count = 0;
	int items_sent = 0;
	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;
	int rx_hold_cycles = 0;
	byte_t topic_buf[$];

	topic_filter_wildcard_match #(
		.MAX_TOPIC_LEN(FILT_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.cmd(cmd),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.is_match(is_match),
		.invalid_filter(invalid_filter)
	);

	always #1 clk = ~clk;

	// Safety net in case the handshakes hang.
	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10) begin
			$display("mismatch: %s", msg);
		end
	endtask

	// Advances the mirrored state by one input byte and queues the verdict it yields.
	function automatic void predict_item(input logic c, input byte_t b, input logic l);
		byte_t f;
		byte_t nxt;
		logic has_next;
		verdict_t v;
		if (c == tfwm_pkg::CMD_FILTER) begin
			if (flt_sealed) begin
				flt_len = 0;
				flt_overflow = 1'b0;
				flt_sealed = 1'b0;
			end
			if (flt_len < FILT_DEPTH) begin
				flt_bytes[flt_len] = b;
				flt_len++;
			end else begin
				flt_overflow = 1'b1;
			end
			if (l) begin
				flt_sealed = 1'b1;
			end
			flt_pos = 0;
			flt_mode = tfwm_pkg::MODE_COMPARE;
			return;
		end
		flt_sealed = 1'b1;
		case (flt_mode)
			tfwm_pkg::MODE_COMPARE: begin
				if (flt_pos >= flt_len) begin
					flt_mode = tfwm_pkg::MODE_FAIL;
				end else begin
					f = flt_bytes[flt_pos];
					has_next = (flt_pos + 1 < flt_len);
					nxt = has_next ? flt_bytes[flt_pos + 1] : 8'h00;
					if (f == tfwm_pkg::CH_PLUS || f == tfwm_pkg::CH_HASH) begin
						if (has_next && nxt != tfwm_pkg::CH_SLASH) begin
							flt_mode = tfwm_pkg::MODE_INVALID;
						end else if (b == tfwm_pkg::CH_SLASH) begin
							if (f == tfwm_pkg::CH_HASH) flt_mode = tfwm_pkg::MODE_INVALID;
							else flt_mode = tfwm_pkg::MODE_FAIL;
						end else if (!has_next) begin
							if (f == tfwm_pkg::CH_HASH) flt_mode = tfwm_pkg::MODE_TAIL;
							else flt_mode = tfwm_pkg::MODE_LAST_LEVEL;
						end else begin
							flt_pos += 2;
							flt_mode = tfwm_pkg::MODE_SKIP_LEVEL;
						end
					end else if (f == b) begin
						flt_pos++;
					end else begin
						flt_mode = tfwm_pkg::MODE_FAIL;
					end
				end
			end
			tfwm_pkg::MODE_SKIP_LEVEL: begin
				if (b == tfwm_pkg::CH_SLASH) flt_mode = tfwm_pkg::MODE_COMPARE;
			end
			tfwm_pkg::MODE_LAST_LEVEL: begin
				if (b == tfwm_pkg::CH_SLASH) flt_mode = tfwm_pkg::MODE_FAIL;
			end
			default: begin
			end
		endcase
		if (!l) begin
			return;
		end
		v.invalid_filter = flt_overflow || flt_mode == tfwm_pkg::MODE_INVALID;
		v.is_match = !v.invalid_filter &&
			((flt_mode == tfwm_pkg::MODE_COMPARE && flt_pos == flt_len) ||
			 flt_mode == tfwm_pkg::MODE_LAST_LEVEL || flt_mode == tfwm_pkg::MODE_TAIL);
		expected_verdicts.push_back(v);
		flt_pos = 0;
		flt_mode = tfwm_pkg::MODE_COMPARE;
	endfunction

	// Checks each result transfer and tracks each input transfer.
	always @(posedge clk) begin : watch_ports
		verdict_t want;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (expected_verdicts.size() == 0) begin
					note_failure($sformatf("unexpected result match=%0b invalid=%0b",
						is_match, invalid_filter));
				end else begin
					want = expected_verdicts.pop_front();
					if (want.is_match !== is_match || want.invalid_filter !== invalid_filter) begin
						note_failure($sformatf("expected match=%0b invalid=%0b, got match=%0b invalid=%0b",
							want.is_match, want.invalid_filter, is_match, invalid_filter));
					end
				end
			end
			if (item_valid && item_ready) begin
				predict_item(cmd, data_byte, last_byte);
			end
		end
	end

	// Result side: random stalls per result, plus an occasional long hold-off.
	initial begin : drain_results
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (rx_hold_cycles > 0) begin
				result_ready <= 1'b0;
				repeat (rx_hold_cycles) @(posedge clk);
				rx_hold_cycles = 0;
			end else begin
				stall = rx_idle ? $urandom_range(0, MAX_WAIT) : 0;
				if (stall > 0) begin
					result_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				result_ready <= 1'b1;
				do @(posedge clk); while (!result_valid && rx_hold_cycles == 0);
			end
		end
	end

	// Offers one byte after a random gap and returns at the edge of its transfer.
	task automatic send_item(input logic c, input byte_t b, input logic l);
		int gap;
		gap = tx_idle ? $urandom_range(0, MAX_WAIT) : 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		cmd <= c;
		data_byte <= b;
		last_byte <= l;
		do @(posedge clk); while (!item_ready);
		items_sent++;
	endtask

	task automatic send_text(input logic c, input string s, input logic seal = 1'b1);
		for (int i = 0; i < s.len(); i++) begin
			send_item(c, s[i], seal && i == s.len() - 1);
		end
	endtask

	task automatic send_bytes(input logic c, input byte_t bytes[$], input logic seal);
		for (int i = 0; i < bytes.size(); i++) begin
			send_item(c, bytes[i], seal && i == bytes.size() - 1);
		end
	endtask

	// A topic against the empty filter left by reset never matches.
	task automatic test_empty_filter();
		send_text(tfwm_pkg::CMD_TOPIC, "a");
	endtask

	// Plain levels must agree byte for byte.
	task automatic test_literal_levels();
		send_text(tfwm_pkg::CMD_FILTER, "a/b");
		send_text(tfwm_pkg::CMD_TOPIC, "a/b");
	endtask

	// A plus takes one level, a final hash takes the rest; a plus on an empty level fails.
	task automatic test_plus_and_tail_hash();
		send_text(tfwm_pkg::CMD_FILTER, "+/#");
		send_text(tfwm_pkg::CMD_TOPIC, "x/y/z");
		send_text(tfwm_pkg::CMD_TOPIC, "/y");
	endtask

	// A hash that is not last acts as a plus; a hash on an empty level is invalid.
	task automatic test_inner_hash();
		send_text(tfwm_pkg::CMD_FILTER, "#/+");
		send_text(tfwm_pkg::CMD_TOPIC, "a/b");
		send_text(tfwm_pkg::CMD_TOPIC, "/b");
	endtask

	// A wildcard followed by anything but a separator marks the filter invalid.
	task automatic test_malformed_wildcard();
		send_text(tfwm_pkg::CMD_FILTER, "+a");
		send_text(tfwm_pkg::CMD_TOPIC, "xa");
	endtask

	// Zero and all-ones bytes are ordinary characters.
	task automatic test_edge_bytes();
		send_bytes(tfwm_pkg::CMD_FILTER, '{8'h00, 8'hFF}, 1'b1);
		send_bytes(tfwm_pkg::CMD_TOPIC, '{8'h00, 8'hFF}, 1'b1);
	endtask

	// A topic byte seals a partly loaded filter; a filter byte restarts matching.
	task automatic test_topic_during_load();
		send_text(tfwm_pkg::CMD_FILTER, "a", 1'b0);
		send_text(tfwm_pkg::CMD_TOPIC, "a");
		send_text(tfwm_pkg::CMD_FILTER, "b");
		send_text(tfwm_pkg::CMD_TOPIC, "c", 1'b0);
		send_text(tfwm_pkg::CMD_FILTER, "d");
		send_text(tfwm_pkg::CMD_TOPIC, "d");
	endtask

	// Receiver holds off while one-byte topics keep coming, so the block must stall its input.
	task automatic test_backpressure();
		tx_idle = 1'b0;
		send_text(tfwm_pkg::CMD_FILTER, "a");
		rx_hold_cycles = 200;
		for (int i = 0; i < 30; i++) begin
			send_item(tfwm_pkg::CMD_TOPIC, "a", 1'b1);
		end
		tx_idle = 1'b1;
	endtask

	function automatic byte_t pick_char();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return "a";
			4: return "b";
			5: return 8'h00;
			6: return 8'hFF;
			7: return "c";
			default: return byte_t'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic void add_level(input int min_len);
		int n;
		n = $urandom_range(min_len, 3);
		if ($urandom_range(0, 9) == 0) n = 0;
		repeat (n) topic_buf.push_back(pick_char());
	endfunction

	// Random filters built from levels, each followed by topics shaped after it.
	task automatic test_random_traffic();
		int nlev, ntop, pick;
		int kind [4];
		int lit_len [4];
		byte_t lit [4][3];
		byte_t flt[$];
		logic seal;
		while (items_sent < 450) begin
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);
			flt.delete();
			nlev = $urandom_range(1, 4);
			for (int i = 0; i < nlev; i++) begin
				pick = $urandom_range(0, 9);
				kind[i] = (pick < 6) ? 0 : (pick < 8) ? 1 : 2;
				if (i > 0) flt.push_back(tfwm_pkg::CH_SLASH);
				if (kind[i] == 0) begin
					lit_len[i] = ($urandom_range(0, 14) == 0) ? 0 : $urandom_range(1, 3);
					for (int j = 0; j < lit_len[i]; j++) begin
						lit[i][j] = pick_char();
						flt.push_back(lit[i][j]);
					end
				end else begin
					flt.push_back(kind[i] == 1 ? tfwm_pkg::CH_PLUS : tfwm_pkg::CH_HASH);
					if ($urandom_range(0, 11) == 0) flt.push_back(pick_char());
				end
			end
			// Now and then a filter just below, at or just past the store depth.
			if ($urandom_range(0, 9) == 0) begin
				pick = FILT_DEPTH - 1 + $urandom_range(0, 3);
				while (flt.size() < pick) flt.push_back(pick_char());
			end
			seal = ($urandom_range(0, 7) != 0);
			send_bytes(tfwm_pkg::CMD_FILTER, flt, seal);

			ntop = $urandom_range(2, 5);
			for (int t = 0; t < ntop; t++) begin
				topic_buf.delete();
				for (int i = 0; i < nlev; i++) begin
					if (i > 0) topic_buf.push_back(tfwm_pkg::CH_SLASH);
					if (kind[i] == 0) begin
						for (int j = 0; j < lit_len[i]; j++) topic_buf.push_back(lit[i][j]);
					end else if (kind[i] == 2 && i == nlev - 1) begin
						add_level(1);
						if ($urandom_range(0, 1) == 1) begin
							topic_buf.push_back(tfwm_pkg::CH_SLASH);
							add_level(1);
						end
					end else begin
						add_level(1);
					end
				end
				// Break some topics on purpose.
				case ($urandom_range(0, 7))
					0: if (topic_buf.size() > 0)
						topic_buf[$urandom_range(0, topic_buf.size() - 1)] = pick_char();
					1: begin
						topic_buf.push_back(tfwm_pkg::CH_SLASH);
						add_level(1);
					end
					2: if (topic_buf.size() > 1) void'(topic_buf.pop_back());
					default: begin
					end
				endcase
				if (topic_buf.size() == 0) topic_buf.push_back(pick_char());
				send_bytes(tfwm_pkg::CMD_TOPIC, topic_buf, 1'b1);
			end

			// Unstructured noise.
			if ($urandom_range(0, 5) == 0) begin
				repeat ($urandom_range(1, 4)) begin
					send_item(logic'($urandom_range(0, 1)), byte_t'($urandom_range(0, 255)),
						logic'($urandom_range(0, 1)));
				end
			end
		end
	endtask

	initial begin : main
		int waited;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_filter();
		test_literal_levels();
		test_plus_and_tail_hash();
		test_inner_hash();
		test_malformed_wildcard();
		test_edge_bytes();
		test_topic_during_load();
		test_backpressure();
		test_random_traffic();
		item_valid <= 1'b0;

		// Drain outstanding results, then allow for the pipeline latency.
		waited = 0;
		while (expected_verdicts.size() > 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		if (expected_verdicts.size() > 0) begin
			$display("missing %0d results", expected_verdicts.size());
			fail_count += expected_verdicts.size();
		end
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
